[design/lob_pkg.sv]
// ----------------------------------------------------------------------------
// lob_pkg
// shared types and constants of the price-level order book
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int ORDER_SLOTS_DEF  = 4096;
  localparam int PRICE_LEVELS_DEF = 1024;
  localparam int QTY_BITS_DEF     = 16;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_DUPLICATE = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] order_id;
    logic        side;
    logic [9:0]  price;
    logic [15:0] quantity;
  } lob_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found_side;
    logic [9:0]  found_price;
    logic [15:0] found_quantity;
    logic [12:0] level_orders;
    logic [27:0] level_quantity;
    logic [9:0]  best_bid;
    logic [10:0] best_ask;
    logic [11:0] spread;
    logic [12:0] buy_total;
    logic [12:0] sell_total;
  } lob_out_t;

endpackage

[design/lob_if.sv]
// ----------------------------------------------------------------------------
// lob_in_if / lob_out_if
// valid/ready channels of the order book
// ----------------------------------------------------------------------------
interface lob_in_if;
  logic             valid;
  logic             ready;
  lob_pkg::lob_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lob_out_if;
  logic              valid;
  logic              ready;
  lob_pkg::lob_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/limit_order_book.sv]
// a transaction passes order read, level read, update, search and finish before its
//   result is valid; one transaction in flight, a new one is taken after the result is accepted
// when a best level empties the search walks that side's level memory one level
//   per cycle until it finds an occupied level or reaches the end of that side
// reset clears control, then a clearing pass over max(ORDER_SLOTS, PRICE_LEVELS)
//   entries empties the memories before the first transaction is taken
// ----------------------------------------------------------------------------
// limit_order_book
// id-indexed order store with per-price level counts and totals per side
// ----------------------------------------------------------------------------
module limit_order_book #(
  parameter int ORDER_SLOTS  = lob_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF,
  parameter int QTY_BITS     = lob_pkg::QTY_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  lob_in_if.sink    in_ch,
  lob_out_if.source out_ch
);
  localparam int IDW  = $clog2(ORDER_SLOTS);
  localparam int PW   = $clog2(PRICE_LEVELS);
  localparam int CLRN = (ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS;
  localparam int CW   = $clog2(CLRN) + 1;
  localparam int SW   = 1 + PW + QTY_BITS + 1;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_UPDATE = 7'b0001000,
    S_SEARCH = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // memories: order store {valid, side, price, qty}; levels {count, qty} per side
  logic [SW-1:0] ord_mem [ORDER_SLOTS];
  logic [40:0]   bid_mem [PRICE_LEVELS];
  logic [40:0]   ask_mem [PRICE_LEVELS];
  logic [SW-1:0] ord_rd_r;
  logic [40:0]   bid_rd_r, ask_rd_r;

  lob_pkg::lob_in_t  req_r;
  lob_pkg::lob_out_t res_r;
  logic              out_valid_r;
  logic [CW-1:0]     clr_r;
  logic [PW:0]       best_bid_r, best_ask_r, scan_r, scan_chk_r;
  logic [12:0]       buy_r, sell_r;
  logic              scan_side_r, scan_bid_r, scan_ask_r, scan_chk_v_r, scan_last_r;
  logic [PW-1:0]     lvl_p;

  wire id_ok = ({4'd0, req_r.order_id} < 16'(ORDER_SLOTS)) || IDW >= 12;
  wire [IDW-1:0] idx = IDW'(req_r.order_id);
  wire pr_ok = ({1'b0, req_r.price} < 11'(PRICE_LEVELS)) || PW >= 10;
  wire [QTY_BITS-1:0] qm = QTY_BITS'(req_r.quantity);

  wire             o_val  = ord_rd_r[SW-1];
  wire             o_side = ord_rd_r[SW-2];
  wire [PW-1:0]    o_pr   = ord_rd_r[SW-3 -: PW];
  wire [QTY_BITS-1:0] o_q = ord_rd_r[QTY_BITS-1:0];
  wire [40:0]      lv_rd  = (req_r.command == lob_pkg::CMD_ADD ? req_r.side : o_side)
                            ? ask_rd_r : bid_rd_r;

  assign lvl_p = (req_r.command == lob_pkg::CMD_ADD) ? PW'(req_r.price) : o_pr;

  // scan read: level memory of the side being searched
  logic [40:0] scan_rd_r;
  wire [PW-1:0] scan_a = PW'(scan_r);
  // scan_rd_r holds the level at scan_chk_r, read in the cycle after its address was issued
  wire scan_end  = scan_bid_r ? (scan_r <= (PW+1)'(1))
                              : (scan_r >= (PW+1)'(PRICE_LEVELS - 1));
  wire scan_hit  = scan_chk_v_r && (scan_rd_r[40:28] != '0);
  wire scan_stop = scan_hit || (scan_chk_v_r && scan_last_r);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (clr_r == CW'(CLRN - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (in_ch.valid) state_nxt = S_READ;
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_SEARCH;
      S_SEARCH: if (!scan_bid_r && !scan_ask_r) state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  logic        upd_we, upd_side, upd_ok;
  logic [40:0] upd_val;
  logic [1:0]  upd_st;

  always_comb begin
    logic [12:0] c;
    logic [27:0] q;
    c = lv_rd[40:28];
    q = lv_rd[27:0];
    upd_we = 1'b0; upd_ok = 1'b0;
    upd_side = (req_r.command == lob_pkg::CMD_ADD) ? req_r.side : o_side;
    upd_st = lob_pkg::ST_DONE;
    case (req_r.command)
      lob_pkg::CMD_ADD: begin
        if (!pr_ok || req_r.price == '0 || qm == '0 || !id_ok) upd_st = lob_pkg::ST_INVALID;
        else if (o_val) upd_st = lob_pkg::ST_DUPLICATE;
        else begin
          upd_we = 1'b1; upd_ok = 1'b1;
          c = c + 13'd1;
          q = q + 28'(qm);
        end
      end
      lob_pkg::CMD_CANCEL, lob_pkg::CMD_LOOKUP: begin
        if (!id_ok || !o_val) upd_st = lob_pkg::ST_NOT_FOUND;
        else begin
          upd_ok = 1'b1;
          if (req_r.command == lob_pkg::CMD_CANCEL) begin
            upd_we = 1'b1;
            if (c != '0) c = c - 13'd1;
            q = (q >= 28'(o_q)) ? q - 28'(o_q) : '0;
            if (c == '0) q = '0;
          end
        end
      end
      default: upd_st = lob_pkg::ST_INVALID;
    endcase
    upd_val = {c, q};
  end

  lob_pkg::lob_out_t res_nxt;

  always_comb begin
    res_nxt = res_r;
    if (state_r == S_UPDATE) begin
      res_nxt = '0;
      res_nxt.status = upd_st;
      if (upd_ok) begin
        res_nxt.level_orders   = upd_val[40:28];
        res_nxt.level_quantity = upd_val[27:0];
        if (req_r.command != lob_pkg::CMD_ADD) begin
          res_nxt.found_side     = o_side;
          res_nxt.found_price    = 10'(o_pr);
          res_nxt.found_quantity = 16'(o_q);
        end
      end
    end else if (state_r == S_FINISH) begin
      res_nxt.best_bid   = 10'(best_bid_r);
      res_nxt.best_ask   = 11'(best_ask_r);
      res_nxt.spread     = (buy_r == '0 || sell_r == '0) ? 12'(PRICE_LEVELS)
                           : 12'(best_ask_r) - 12'(best_bid_r);
      res_nxt.buy_total  = buy_r;
      res_nxt.sell_total = sell_r;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) ord_rd_r <= ord_mem[IDW'(in_ch.data.order_id)];
    if (state_r == S_READ) begin
      bid_rd_r <= bid_mem[lvl_p];
      ask_rd_r <= ask_mem[lvl_p];
    end
    scan_rd_r <= scan_side_r ? ask_mem[scan_a] : bid_mem[scan_a];
    if (state_r == S_CLEAR) begin
      if (clr_r < CW'(ORDER_SLOTS)) ord_mem[IDW'(clr_r)] <= '0;
      if (clr_r < CW'(PRICE_LEVELS)) begin
        bid_mem[PW'(clr_r)] <= '0;
        ask_mem[PW'(clr_r)] <= '0;
      end
    end else if (state_r == S_UPDATE && upd_we) begin
      if (upd_side) ask_mem[lvl_p] <= upd_val;
      else          bid_mem[lvl_p] <= upd_val;
      if (req_r.command == lob_pkg::CMD_ADD)
        ord_mem[idx] <= {1'b1, req_r.side, PW'(req_r.price), qm};
      else
        ord_mem[idx] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; out_valid_r <= 1'b0;
      best_bid_r <= '0; best_ask_r <= (PW+1)'(PRICE_LEVELS);
      buy_r <= '0; sell_r <= '0;
      scan_bid_r <= 1'b0; scan_ask_r <= 1'b0; scan_side_r <= 1'b0; scan_r <= '0;
      scan_chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r <= res_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + CW'(1);
      if (state_r == S_IDLE && in_ch.valid) req_r <= in_ch.data;
      if (state_r == S_UPDATE) begin
        scan_chk_v_r <= 1'b0;
        if (upd_we && req_r.command == lob_pkg::CMD_ADD) begin
          if (!upd_side) begin
            buy_r <= buy_r + 13'd1;
            if ({1'b0, lvl_p} > best_bid_r) best_bid_r <= {1'b0, lvl_p};
          end else begin
            sell_r <= sell_r + 13'd1;
            if ({1'b0, lvl_p} < best_ask_r) best_ask_r <= {1'b0, lvl_p};
          end
        end
        if (upd_we && req_r.command == lob_pkg::CMD_CANCEL) begin
          if (!upd_side) begin
            if (buy_r != '0) buy_r <= buy_r - 13'd1;
            if (upd_val[40:28] == '0 && {1'b0, lvl_p} == best_bid_r) begin
              scan_bid_r <= 1'b1; scan_side_r <= 1'b0; best_bid_r <= '0;
              scan_r <= {1'b0, lvl_p} - (PW+1)'(1);
            end
          end else begin
            if (sell_r != '0) sell_r <= sell_r - 13'd1;
            if (upd_val[40:28] == '0 && {1'b0, lvl_p} == best_ask_r) begin
              scan_ask_r <= 1'b1; scan_side_r <= 1'b1;
              best_ask_r <= (PW+1)'(PRICE_LEVELS);
              scan_r <= {1'b0, lvl_p} + (PW+1)'(1);
            end
          end
        end
      end
      // walk away from the emptied best level, checking one level per cycle
      if (state_r == S_SEARCH && (scan_bid_r || scan_ask_r)) begin
        scan_chk_v_r <= !scan_stop;
        scan_chk_r   <= scan_r;
        scan_last_r  <= scan_end;
        if (!scan_end) scan_r <= scan_bid_r ? scan_r - (PW+1)'(1) : scan_r + (PW+1)'(1);
        if (scan_stop) begin
          scan_bid_r <= 1'b0; scan_ask_r <= 1'b0;
          if (scan_hit && scan_bid_r) best_bid_r <= scan_chk_r;
          if (scan_hit && scan_ask_r) best_ask_r <= scan_chk_r;
        end
      end
      if (state_r == S_FINISH) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
    end
  end

endmodule

[verif/lob_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_checker
// watches both channels of the order book, keeps a shadow book, predicts the
// result of every accepted transaction and compares it field by field
// ----------------------------------------------------------------------------
module lob_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  lob_pkg::lob_in_t         in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  lob_pkg::lob_out_t        out_data,
  output int                       error_count,
  output int                       pending_count
);

  localparam int NSLOT = lob_pkg::ORDER_SLOTS_DEF;
  localparam int NLVL  = lob_pkg::PRICE_LEVELS_DEF;

  logic        slot_live [NSLOT];
  logic        slot_side [NSLOT];
  logic [9:0]  slot_price [NSLOT];
  logic [15:0] slot_qty [NSLOT];
  int          lvl_cnt [2][NLVL];
  longint      lvl_qty [2][NLVL];
  int          side_cnt [2];

  lob_pkg::lob_out_t expected_results [$];

  initial error_count = 0;
  assign pending_count = expected_results.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic lob_pkg::lob_out_t book_step(input lob_pkg::lob_in_t t);
    lob_pkg::lob_out_t r;
    int p, s, bb, ba;
    r = '0;
    if (t.command == lob_pkg::CMD_ADD) begin
      if (t.price == 0 || t.quantity == 0) r.status = lob_pkg::ST_INVALID;
      else if (slot_live[t.order_id]) r.status = lob_pkg::ST_DUPLICATE;
      else begin
        s = int'(t.side); p = int'(t.price);
        slot_live[t.order_id] = 1'b1;
        slot_side[t.order_id] = t.side;
        slot_price[t.order_id] = t.price;
        slot_qty[t.order_id] = t.quantity;
        lvl_cnt[s][p]++;
        lvl_qty[s][p] += longint'(t.quantity);
        side_cnt[s]++;
        r.level_orders = 13'(lvl_cnt[s][p]);
        r.level_quantity = 28'(lvl_qty[s][p]);
      end
    end else if (t.command == lob_pkg::CMD_CANCEL || t.command == lob_pkg::CMD_LOOKUP) begin
      if (!slot_live[t.order_id]) r.status = lob_pkg::ST_NOT_FOUND;
      else begin
        s = int'(slot_side[t.order_id]); p = int'(slot_price[t.order_id]);
        r.found_side = slot_side[t.order_id];
        r.found_price = slot_price[t.order_id];
        r.found_quantity = slot_qty[t.order_id];
        if (t.command == lob_pkg::CMD_CANCEL) begin
          if (lvl_cnt[s][p] != 0) lvl_cnt[s][p]--;
          lvl_qty[s][p] = (lvl_qty[s][p] >= longint'(slot_qty[t.order_id])) ?
                          lvl_qty[s][p] - longint'(slot_qty[t.order_id]) : 64'sd0;
          if (lvl_cnt[s][p] == 0) lvl_qty[s][p] = 0;
          if (side_cnt[s] != 0) side_cnt[s]--;
          slot_live[t.order_id] = 1'b0;
        end
        r.level_orders = 13'(lvl_cnt[s][p]);
        r.level_quantity = 28'(lvl_qty[s][p]);
      end
    end else begin
      r.status = lob_pkg::ST_INVALID;
    end
    bb = 0; ba = NLVL;
    for (int i = NLVL - 1; i > 0; i--) if (lvl_cnt[0][i] != 0) begin bb = i; break; end
    for (int i = 0; i < NLVL; i++) if (lvl_cnt[1][i] != 0) begin ba = i; break; end
    r.best_bid = 10'(bb);
    r.best_ask = 11'(ba);
    r.spread = 12'((side_cnt[0] == 0 || side_cnt[1] == 0) ? NLVL : ba - bb);
    r.buy_total = 13'(side_cnt[0]);
    r.sell_total = 13'(side_cnt[1]);
    return r;
  endfunction

  always @(posedge clk) begin
    lob_pkg::lob_out_t e;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) slot_live[i] = 1'b0;
      for (int i = 0; i < NLVL; i++) begin
        lvl_cnt[0][i] = 0; lvl_cnt[1][i] = 0; lvl_qty[0][i] = 0; lvl_qty[1][i] = 0;
      end
      side_cnt[0] = 0; side_cnt[1] = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction pending", 1, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_data.status != e.status) report_mismatch("status", out_data.status, e.status);
          if (out_data.found_side != e.found_side)
            report_mismatch("found_side", out_data.found_side, e.found_side);
          if (out_data.found_price != e.found_price)
            report_mismatch("found_price", out_data.found_price, e.found_price);
          if (out_data.found_quantity != e.found_quantity)
            report_mismatch("found_quantity", out_data.found_quantity, e.found_quantity);
          if (out_data.level_orders != e.level_orders)
            report_mismatch("level_orders", out_data.level_orders, e.level_orders);
          if (out_data.level_quantity != e.level_quantity)
            report_mismatch("level_quantity", out_data.level_quantity, e.level_quantity);
          if (out_data.best_bid != e.best_bid)
            report_mismatch("best_bid", out_data.best_bid, e.best_bid);
          if (out_data.best_ask != e.best_ask)
            report_mismatch("best_ask", out_data.best_ask, e.best_ask);
          if (out_data.spread != e.spread)
            report_mismatch("spread", $signed(out_data.spread), $signed(e.spread));
          if (out_data.buy_total != e.buy_total)
            report_mismatch("buy_total", out_data.buy_total, e.buy_total);
          if (out_data.sell_total != e.sell_total)
            report_mismatch("sell_total", out_data.sell_total, e.sell_total);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(book_step(in_data));
    end
  end

endmodule

[verif/tb_limit_order_book.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_limit_order_book
// directed and random order traffic (adds, cancels, lookups, bad and
// duplicate orders) under several idle and stall patterns; a checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_limit_order_book;

  localparam int IDLE_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   error_count, pending_count;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;
  int   idle_cycles = 0;

  lob_in_if  in_ch ();
  lob_out_if out_ch ();

  limit_order_book i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  lob_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .error_count(error_count), .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  // ids live in a small pool so cancels and lookups usually hit
  logic [11:0] live_ids [$];

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on accepted transactions; covers the clearing pass after reset
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_limit_order_book: done, errors");
      $finish;
    end
  end

  task automatic send_txn(input logic [1:0] cmd, input logic [11:0] id, input logic sd,
                          input logic [9:0] pr, input logic [15:0] qt);
    lob_pkg::lob_in_t t;
    t.command = cmd; t.order_id = id; t.side = sd; t.price = pr; t.quantity = qt;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd == lob_pkg::CMD_ADD) live_ids.push_back(id);
  endtask

  task automatic release_bus();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    release_bus();
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic random_txn();
    int r;
    logic [11:0] id;
    logic [9:0] pr;
    r = $urandom_range(99);
    id = (live_ids.size() != 0 && $urandom_range(3) != 0) ?
         live_ids[$urandom_range(live_ids.size() - 1)] : 12'($urandom);
    pr = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(520, 480));
    if (r < 50)
      send_txn(lob_pkg::CMD_ADD, ($urandom_range(4) == 0) ? id : 12'($urandom), 1'($urandom),
               ($urandom_range(30) == 0) ? 10'd0 : pr,
               ($urandom_range(30) == 0) ? 16'd0 : 16'($urandom));
    else if (r < 75)
      send_txn(lob_pkg::CMD_CANCEL, id, 1'($urandom), 10'($urandom), 16'($urandom));
    else if (r < 95)
      send_txn(lob_pkg::CMD_LOOKUP, id, 1'($urandom), 10'($urandom), 16'($urandom));
    else send_txn(lob_pkg::CMD_UNUSED, id, 1'($urandom), 10'($urandom), 16'($urandom));
    if (live_ids.size() > 200) live_ids.delete(0);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command, bad and duplicate orders
    send_txn(lob_pkg::CMD_LOOKUP, 12'd0, 1'b0, 10'd0, 16'd0);
    send_txn(lob_pkg::CMD_CANCEL, 12'hfff, 1'b1, 10'd0, 16'd0);
    send_txn(lob_pkg::CMD_ADD, 12'd1, 1'b0, 10'd0, 16'd5);
    send_txn(lob_pkg::CMD_ADD, 12'd2, 1'b0, 10'd5, 16'd0);
    send_txn(lob_pkg::CMD_ADD, 12'd0, 1'b0, 10'd1, 16'd1);
    send_txn(lob_pkg::CMD_ADD, 12'hfff, 1'b1, 10'h3ff, 16'hffff);
    send_txn(lob_pkg::CMD_ADD, 12'd3, 1'b0, 10'h3ff, 16'hffff);
    send_txn(lob_pkg::CMD_ADD, 12'd4, 1'b1, 10'd1, 16'h8000);
    send_txn(lob_pkg::CMD_ADD, 12'd5, 1'b1, 10'd1, 16'h7fff);
    send_txn(lob_pkg::CMD_ADD, 12'd0, 1'b1, 10'd7, 16'd9);
    send_txn(lob_pkg::CMD_LOOKUP, 12'hfff, 1'b0, 10'd0, 16'd0);
    send_txn(lob_pkg::CMD_LOOKUP, 12'd5, 1'b0, 10'd0, 16'd0);
    send_txn(lob_pkg::CMD_UNUSED, 12'd5, 1'b1, 10'd3, 16'd3);
    send_txn(lob_pkg::CMD_CANCEL, 12'd4, 1'b0, 10'd0, 16'd0);
    send_txn(lob_pkg::CMD_CANCEL, 12'd5, 1'b0, 10'd0, 16'd0);
    send_txn(lob_pkg::CMD_CANCEL, 12'd5, 1'b0, 10'd0, 16'd0);
    send_txn(lob_pkg::CMD_CANCEL, 12'd3, 1'b0, 10'd0, 16'd0);
    send_txn(lob_pkg::CMD_CANCEL, 12'd0, 1'b0, 10'd0, 16'd0);
    send_txn(lob_pkg::CMD_CANCEL, 12'hfff, 1'b0, 10'd0, 16'd0);
    send_txn(lob_pkg::CMD_ADD, 12'd0, 1'b1, 10'd2, 16'd2);
    drain();

    // random phases; last one checks the no-idle stretch again
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        3: begin send_idle_pct = 35; recv_stall_pct = 35; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) begin
        // long receiver hold-off while the sender keeps offering
        fork
          begin hold_off = 1'b1; repeat (300) @(posedge clk); hold_off = 1'b0; end
          repeat (30) random_txn();
        join
      end
      repeat (180) random_txn();
      drain();
    end

    release_bus();
    repeat (2000) begin
      if (pending_count == 0) break;
      @(posedge clk);
    end
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_count == 0) $display("tb_limit_order_book: done, clean");
    else $display("tb_limit_order_book: done, errors");
    $finish;
  end

endmodule
